// ===== hdl/tlp_pkg.sv =====
// Shared types and constants of the trimmed latency profiler.
package tlp_pkg;

	localparam int TAG_W         = 6;
	localparam int TS_W          = 63;
	localparam int TIME_W        = 64;
	localparam int CNT_W         = 32;
	localparam int TAG_SLOTS_DEF = 64;

	localparam logic [CNT_W-1:0] TRIM_N    = CNT_W'(4);
	localparam logic [CNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [1:0] {
		ACT_BEGIN = 2'd0,
		ACT_END   = 2'd1,
		ACT_READ  = 2'd2,
		ACT_CLEAR = 2'd3
	} action_t;

	typedef struct packed {
		logic [TS_W-1:0]   start;
		logic [TIME_W-1:0] total;
		logic [TIME_W-1:0] s_min;
		logic [TIME_W-1:0] s_min2;
		logic [TIME_W-1:0] s_max2;
		logic [TIME_W-1:0] s_max;
		logic [CNT_W-1:0]  count;
	} entry_t;

endpackage

// ===== hdl/tlp_in_if.sv =====
// Event word channel of the profiler.
interface tlp_in_if import tlp_pkg::*; ();
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [TAG_W-1:0]  tag;
	logic [TS_W-1:0]   timestamp;

	modport source (output valid, action, tag, timestamp, input ready);
	modport sink (input valid, action, tag, timestamp, output ready);
endinterface

// ===== hdl/tlp_out_if.sv =====
// Statistics word channel of the profiler.
interface tlp_out_if import tlp_pkg::*; ();
	logic                     valid;
	logic                     ready;
	logic [CNT_W-1:0]         call_count;
	logic signed [TIME_W-1:0] min_time;
	logic signed [TIME_W-1:0] max_time;
	logic signed [TIME_W-1:0] trimmed_total;
	logic [CNT_W-1:0]         trimmed_divisor;

	modport source (output valid, call_count, min_time, max_time, trimmed_total,
		trimmed_divisor, input ready);
	modport sink (input valid, call_count, min_time, max_time, trimmed_total,
		trimmed_divisor, output ready);
endinterface

// ===== hdl/tlp_table.sv =====
// Statistics table: one write port, one registered read port.
module tlp_table import tlp_pkg::*; #(
	parameter int SLOTS = TAG_SLOTS_DEF,
	parameter int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
	input  logic             clk,
	input  logic             rd_en,
	input  logic [IDX_W-1:0] rd_addr,
	output entry_t           rd_data,
	input  logic             wr_en,
	input  logic [IDX_W-1:0] wr_addr,
	input  entry_t           wr_data
);

	entry_t mem [SLOTS];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

// ===== hdl/tlp_merge.sv =====
// Folds one delta into an entry: total, sorted extremes and count.
module tlp_merge import tlp_pkg::*; (
	input  entry_t            cur,
	input  logic [TIME_W-1:0] delta,
	output entry_t            nxt
);

	logic [TIME_W-1:0] kept [4];
	logic [TIME_W-1:0] srt [5];
	logic [3:0]        below;

	always_comb begin
		kept[0] = cur.s_min;
		kept[1] = cur.s_min2;
		kept[2] = cur.s_max2;
		kept[3] = cur.s_max;
		for (int k = 0; k < 4; k++) begin
			below[k] = $signed(kept[k]) < $signed(delta);
		end
		// kept is sorted, so below is a thermometer code
		srt[0] = below[0] ? kept[0] : delta;
		for (int i = 1; i < 4; i++) begin
			srt[i] = below[i] ? kept[i] : (below[i-1] ? delta : kept[i-1]);
		end
		srt[4] = below[3] ? delta : kept[3];

		nxt       = cur;
		nxt.total = cur.total + delta;
		if (cur.count < TRIM_N) begin
			nxt.s_min  = srt[1];
			nxt.s_min2 = srt[2];
		end else begin
			nxt.s_min  = srt[0];
			nxt.s_min2 = srt[1];
		end
		nxt.s_max2 = srt[3];
		nxt.s_max  = srt[4];
		nxt.count  = (cur.count == COUNT_MAX) ? cur.count : cur.count + CNT_W'(1);
	end

endmodule

// ===== hdl/trimmed_latency_profiler.sv =====
// Top level of the trimmed latency profiler.
//
// Usage: event words enter on item (action, tag, timestamp); every word gives
// exactly one statistics word on result. Begin stores a start time, end folds
// the delta into the tag's entry, read reports count, min, max, trimmed total
// and divisor, clear zeroes the table. Only read gives non-zero fields; a tag
// at or above TAG_SLOTS is ignored and reads as zero.
// One word is in flight at a time, through the single table read port and
// then the read-modify-write of the entry: begin writes the start time in
// S_LOAD; end forms the delta in S_LOAD and writes the merged entry in
// S_ALTER; read goes on through S_TRIM and S_FINAL with the subtractions;
// clear runs the sweep. The result register is loaded at the last step.
// After reset the table is swept to zero, one entry a cycle, over every
// entry with item.ready low. A clear runs the same sweep.
// If result is stalled, the finished word waits in the result register and
// the next word is still taken; a second one holds in its last step until
// the register empties.
module trimmed_latency_profiler import tlp_pkg::*; #(
	parameter int TAG_SLOTS = TAG_SLOTS_DEF
) (
	input logic            clk,
	input logic            arst_n,
	tlp_in_if.sink         item,
	tlp_out_if.source      result
);

	localparam int IDX_W  = (TAG_SLOTS > 1) ? $clog2(TAG_SLOTS) : 1;
	localparam int SPAN_W = ((IDX_W > TAG_W) ? IDX_W : TAG_W) + 1;

	typedef enum logic [2:0] {
		S_SWEEP,
		S_IDLE,
		S_LOAD,
		S_ALTER,
		S_TRIM,
		S_FINAL
	} state_t;

	state_t            state_q;
	action_t           op_q;
	logic              hit_q;
	logic [IDX_W-1:0]  addr_q;
	logic [TS_W-1:0]   ts_q;
	logic [TIME_W-1:0] delta_q;
	logic [TIME_W-1:0] sum_q;
	logic [TIME_W-1:0] part_q;
	logic [IDX_W-1:0]  sweep_q;
	logic              reply_q;

	logic              res_valid_q;
	logic [CNT_W-1:0]  res_count_q;
	logic [TIME_W-1:0] res_min_q;
	logic [TIME_W-1:0] res_max_q;
	logic [TIME_W-1:0] res_total_q;
	logic [CNT_W-1:0]  res_div_q;

	logic [SPAN_W-1:0] tag_ext;
	logic              tag_hit;
	logic [IDX_W-1:0]  tag_addr;
	logic              rd_en;
	entry_t            rd_data;
	logic              wr_en;
	logic [IDX_W-1:0]  wr_addr;
	entry_t            wr_data;
	entry_t            merged;
	logic              ok;
	logic              last;
	logic              emit;
	logic              emit_read;

	assign tag_ext  = SPAN_W'(item.tag);
	assign tag_hit  = tag_ext < SPAN_W'(TAG_SLOTS);
	assign tag_addr = tag_ext[IDX_W-1:0];

	assign item.ready = (state_q == S_IDLE);
	assign rd_en      = item.valid && item.ready;
	assign ok         = !res_valid_q || result.ready;
	assign last       = (sweep_q == IDX_W'(TAG_SLOTS - 1));

	tlp_table #(
		.SLOTS (TAG_SLOTS),
		.IDX_W (IDX_W)
	) u_table (
		.clk     (clk),
		.rd_en   (rd_en),
		.rd_addr (tag_addr),
		.rd_data (rd_data),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	tlp_merge u_merge (
		.cur   (rd_data),
		.delta (delta_q),
		.nxt   (merged)
	);

	always_comb begin
		wr_en     = 1'b0;
		wr_addr   = addr_q;
		wr_data   = rd_data;
		emit      = 1'b0;
		emit_read = 1'b0;
		unique case (state_q)
			S_SWEEP: begin
				wr_en   = 1'b1;
				wr_addr = sweep_q;
				wr_data = '0;
				emit    = last && reply_q && ok;
			end
			S_LOAD: begin
				if (op_q == ACT_BEGIN) begin
					emit = ok;
					if (hit_q) begin
						wr_en         = ok;
						wr_data.start = ts_q;
					end
				end else if (!hit_q) begin
					emit = ok;
				end
			end
			S_ALTER: begin
				emit    = ok;
				wr_en   = ok;
				wr_data = merged;
			end
			S_FINAL: begin
				emit      = ok;
				emit_read = ok;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_SWEEP;
			sweep_q     <= '0;
			reply_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end

			if (emit) begin
				res_count_q <= '0;
				res_min_q   <= '0;
				res_max_q   <= '0;
				res_total_q <= '0;
				res_div_q   <= '0;
				if (emit_read) begin
					res_count_q <= rd_data.count;
					res_min_q   <= rd_data.s_min;
					res_max_q   <= rd_data.s_max;
					if (rd_data.count >= TRIM_N) begin
						res_total_q <= part_q - sum_q;
						res_div_q   <= rd_data.count - TRIM_N;
					end else begin
						res_total_q <= rd_data.total;
						res_div_q   <= rd_data.count;
					end
				end
			end

			unique case (state_q)
				S_SWEEP: begin
					if (!last) begin
						sweep_q <= sweep_q + IDX_W'(1);
					end else if (!reply_q || ok) begin
						reply_q <= 1'b0;
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (item.valid) begin
						op_q   <= action_t'(item.action);
						hit_q  <= tag_hit;
						addr_q <= tag_addr;
						ts_q   <= item.timestamp;
						if (action_t'(item.action) == ACT_CLEAR) begin
							sweep_q <= '0;
							reply_q <= 1'b1;
							state_q <= S_SWEEP;
						end else begin
							state_q <= S_LOAD;
						end
					end
				end
				S_LOAD: begin
					if (op_q == ACT_BEGIN || !hit_q) begin
						if (ok) begin
							state_q <= S_IDLE;
						end
					end else if (op_q == ACT_END) begin
						delta_q <= TIME_W'(ts_q) - TIME_W'(rd_data.start);
						state_q <= S_ALTER;
					end else begin
						sum_q   <= rd_data.s_min + rd_data.s_min2;
						state_q <= S_TRIM;
					end
				end
				S_ALTER: begin
					if (ok) begin
						state_q <= S_IDLE;
					end
				end
				S_TRIM: begin
					part_q  <= rd_data.total - sum_q;
					sum_q   <= rd_data.s_max2 + rd_data.s_max;
					state_q <= S_FINAL;
				end
				S_FINAL: begin
					if (ok) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_SWEEP;
				end
			endcase
		end
	end

	assign result.valid           = res_valid_q;
	assign result.call_count      = res_count_q;
	assign result.min_time        = res_min_q;
	assign result.max_time        = res_max_q;
	assign result.trimmed_total   = res_total_q;
	assign result.trimmed_divisor = res_div_q;

`ifndef SYNTHESIS
	// extremes written back by an end stay in ascending order
	a_sorted: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == S_ALTER) |->
			($signed(wr_data.s_min) <= $signed(wr_data.s_min2)) &&
			($signed(wr_data.s_min2) <= $signed(wr_data.s_max2)) &&
			($signed(wr_data.s_max2) <= $signed(wr_data.s_max)))
		else $error("extremes out of order");

	// count steps by one, or holds at saturation
	a_count: assert property (@(posedge clk) disable iff (!arst_n)
		(wr_en && state_q == S_ALTER) |->
			((wr_data.count == rd_data.count + CNT_W'(1)) ||
			(rd_data.count == COUNT_MAX && wr_data.count == COUNT_MAX)))
		else $error("end count step wrong");

	// words other than read carry zero fields
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(emit && !emit_read) |=>
			(result.call_count == '0 && result.trimmed_divisor == '0 &&
			result.min_time == '0 && result.max_time == '0 &&
			result.trimmed_total == '0))
		else $error("non-read word not zero");

	// no new word while the table is being swept
	a_sweep: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SWEEP && !last) |=> (state_q == S_SWEEP))
		else $error("sweep left early");
`endif

endmodule
